// ===== src/sapq_pkg.sv =====
package sapq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 6;

  typedef enum logic [0:0] {
    CmdInsert = 1'b0,
    CmdRemove = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                     command;
    logic signed [ValueW-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [ValueW-1:0] removed_value;
    logic [CountW-1:0]        count;
    logic                     is_empty;
    logic                     is_full;
  } out_item_t;

  // broadcast to every cell
  typedef struct packed {
    logic                     insert;
    logic                     remove;
    logic signed [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== src/sapq_cell.sv =====
module sapq_cell (
  input  logic                                clk_i,
  input  sapq_pkg::cell_ctrl_t                ctrl_i,
  input  logic                                occupied_i,
  input  logic signed [sapq_pkg::ValueW-1:0]  left_entry_i,
  input  logic                                left_shift_i,
  input  logic signed [sapq_pkg::ValueW-1:0]  right_entry_i,
  output logic signed [sapq_pkg::ValueW-1:0]  entry_o,
  output logic                                shift_o
);

  logic signed [sapq_pkg::ValueW-1:0] entry_q, entry_d;

  // entry moves up on insert when it is strictly larger than the new value
  assign shift_o = occupied_i && (entry_q > ctrl_i.value);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (left_shift_i) begin
        entry_d = left_entry_i;
      end else if (shift_o || !occupied_i) begin
        entry_d = ctrl_i.value;
      end
    end else if (ctrl_i.remove) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== src/sorted_array_priority_queue_top.sv =====
// Sorted-array min priority queue built from a row of DEPTH cells.
// Input channel: in_valid_i / in_stall_o carry one command item, either
// insert a signed value or remove the smallest value. Output channel:
// out_valid_o / out_stall_i carry one result item for each command, with
// status, removed value, count after the item and empty/full flags.
// Equal values leave in the order they were inserted.
// Every cell compares its entry with the broadcast value and takes its own,
// its left or its right neighbor's entry, so the whole row updates at once:
// the result appears in the cycle after the item is accepted, and one
// item per cycle is sustained while the receiver keeps up.
// The result waits in an output register; while it is stalled, in_stall_o
// is held high and no new item is taken.
// Reset empties the queue and drops any pending result; the stored entries
// are not cleared, the fill count marks which of them are held.
module sorted_array_priority_queue_top #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sapq_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sapq_pkg::out_item_t  out_item_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);

  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q;
  sapq_pkg::out_item_t out_item_q, out_item_d;

  logic accept, is_insert, insert_ok, remove_ok;
  sapq_pkg::cell_ctrl_t ctrl;

  logic signed [sapq_pkg::ValueW-1:0] entry [DEPTH];
  logic                               shift [DEPTH];

  logic [sapq_pkg::CountW+CW-1:0] count_ext;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_insert  = (in_item_i.command == sapq_pkg::CmdInsert);
  assign insert_ok  = accept && is_insert && (count_q != FullCount);
  assign remove_ok  = accept && !is_insert && (count_q != '0);

  assign ctrl.insert = insert_ok;
  assign ctrl.remove = remove_ok;
  assign ctrl.value  = in_item_i.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] Idx = CW'(i);
    logic signed [sapq_pkg::ValueW-1:0] left_entry, right_entry;
    logic                               left_shift;

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_shift = 1'b0;
    end else begin : g_mid
      assign left_entry = entry[i-1];
      assign left_shift = shift[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    sapq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (Idx < count_q),
      .left_entry_i  (left_entry),
      .left_shift_i  (left_shift),
      .right_entry_i (right_entry),
      .entry_o       (entry[i]),
      .shift_o       (shift[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (insert_ok) begin
      count_d = count_q + CW'(1);
    end else if (remove_ok) begin
      count_d = count_q - CW'(1);
    end
  end

  assign count_ext = {{sapq_pkg::CountW{1'b0}}, count_d};

  always_comb begin
    out_item_d.status        = sapq_pkg::StDone;
    out_item_d.removed_value = '0;
    out_item_d.count         = count_ext[sapq_pkg::CountW-1:0];
    out_item_d.is_empty      = (count_d == '0);
    out_item_d.is_full       = (count_d == FullCount);
    if (is_insert) begin
      if (!insert_ok) begin
        out_item_d.status = sapq_pkg::StFull;
      end
    end else if (remove_ok) begin
      out_item_d.removed_value = entry[0];
    end else begin
      out_item_d.status = sapq_pkg::StEmpty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== tb/sv/sapq_result_check.sv =====
`timescale 1ns / 100ps
module sapq_result_check #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  sapq_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  sapq_pkg::out_item_t out_item_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  // ascending, equal values in arrival order
  logic signed [sapq_pkg::ValueW-1:0] queued_values[$];
  sapq_pkg::out_item_t                pending_results[$];
  int unsigned                        mismatches = 0;

  function automatic sapq_pkg::out_item_t predict_result(sapq_pkg::in_item_t cmd);
    sapq_pkg::out_item_t                res;
    int unsigned                        pos;
    logic signed [sapq_pkg::ValueW-1:0] v;
    res = '0;
    res.status = sapq_pkg::StDone;
    v = cmd.value;
    if (cmd.command == sapq_pkg::CmdInsert) begin
      if (queued_values.size() >= DEPTH) begin
        res.status = sapq_pkg::StFull;
      end else begin
        pos = queued_values.size();
        while (pos > 0 && queued_values[pos-1] > v) pos--;
        queued_values.insert(pos, v);
      end
    end else begin
      if (queued_values.size() == 0) begin
        res.status = sapq_pkg::StEmpty;
      end else begin
        res.removed_value = queued_values.pop_front();
      end
    end
    res.count    = sapq_pkg::CountW'(queued_values.size());
    res.is_empty = (queued_values.size() == 0);
    res.is_full  = (queued_values.size() == DEPTH);
    return res;
  endfunction

  task automatic compare_result(sapq_pkg::out_item_t got);
    sapq_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result with nothing pending: expected none, actual %p", $time, got);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status: expected %0d, actual %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.removed_value !== want.removed_value) begin
        $display("%0t: removed_value: expected %0d, actual %0d", $time,
                 want.removed_value, got.removed_value);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $display("%0t: count: expected %0d, actual %0d", $time, want.count, got.count);
        mismatches++;
      end
      if (got.is_empty !== want.is_empty) begin
        $display("%0t: is_empty: expected %0b, actual %0b", $time, want.is_empty,
                 got.is_empty);
        mismatches++;
      end
      if (got.is_full !== want.is_full) begin
        $display("%0t: is_full: expected %0b, actual %0b", $time, want.is_full, got.is_full);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_values.delete();
      pending_results.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (out_valid_i && !out_stall_i) compare_result(out_item_i);
      if (in_valid_i && !in_stall_i) pending_results.push_back(predict_result(in_item_i));
      pending_o    <= pending_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== tb/sv/tb_sorted_array_priority_queue_top.sv =====
`timescale 1ns / 100ps
module tb_sorted_array_priority_queue_top;

  localparam int unsigned DEPTH      = 32;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 120;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  sapq_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sapq_pkg::out_item_t out_item;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;
  bit          hold_req       = 1'b0;

  sorted_array_priority_queue_top #(.DEPTH(DEPTH)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  sapq_result_check #(.DEPTH(DEPTH)) u_result_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [sapq_pkg::ValueW-1:0] pick_value();
    logic signed [sapq_pkg::ValueW-1:0] v;
    case ($urandom_range(7))
      0, 1: v = int'($urandom_range(8)) - 4;
      2: begin
        case ($urandom_range(3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic send_item(input sapq_pkg::cmd_e cmd,
                           input logic signed [sapq_pkg::ValueW-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{command: cmd, value: val};
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  function automatic sapq_pkg::cmd_e pick_cmd(input int unsigned remove_odds);
    return ($urandom_range(remove_odds) == 0) ? sapq_pkg::CmdRemove : sapq_pkg::CmdInsert;
  endfunction

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (26) send_item(pick_cmd(1), pick_value());
    // fill past full, then drain past empty
    repeat (DEPTH + 2) send_item(sapq_pkg::CmdInsert, pick_value());
    repeat (10) send_item(pick_cmd(1), pick_value());
    repeat (DEPTH + 2) send_item(sapq_pkg::CmdRemove, pick_value());
  endtask

  // receiver: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        for (int k = 0; k < HoldCycles; k++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(sapq_pkg::CmdRemove, 32'sh7fff_ffff);
    send_item(sapq_pkg::CmdInsert, 32'sh7fff_ffff);
    send_item(sapq_pkg::CmdInsert, 32'sh8000_0000);
    send_item(sapq_pkg::CmdInsert, 32'sh0000_0000);
    send_item(sapq_pkg::CmdInsert, 32'shffff_ffff);
    send_item(sapq_pkg::CmdInsert, 32'sh0000_0001);
    send_item(sapq_pkg::CmdInsert, 32'sh0000_0000);
    send_item(sapq_pkg::CmdInsert, 32'sh5555_5555);
    send_item(sapq_pkg::CmdInsert, 32'shaaaa_aaaa);
    repeat (8) send_item(sapq_pkg::CmdRemove, 32'sh8000_0000);
    send_item(sapq_pkg::CmdRemove, 32'sh0000_0000);

    run_phase(0, 0);

    // long receiver hold-off while items keep coming
    hold_req = 1'b1;
    repeat (16) send_item(pick_cmd(3), pick_value());
    // sender pause until every result is back
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    run_phase(62, 0);
    run_phase(0, 62);
    run_phase(23, 23);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
